FILE: hw/rtl/vln_pkg.sv
// Package for the vector length normalize unit.
// Holds the request and result payload types, the field widths, the dimension limits and the value of one.
// Used by every module in hw/rtl.
package vln_pkg;

  // Field widths of the request and result payloads.
  localparam int unsigned COMP_W   = 16;
  localparam int unsigned UNIT_W   = 16;
  localparam int unsigned MAG_W    = 17;
  localparam int unsigned MSQ_W    = 33;
  localparam int unsigned DIM_W    = 3;
  localparam int unsigned QUOT_W   = 16;
  localparam int unsigned LANES    = 4;

  // Dimension register limits and reset value.
  localparam logic [DIM_W-1:0] DIM_MIN   = 3'd2;
  localparam logic [DIM_W-1:0] DIM_MAX   = 3'd4;
  localparam logic [DIM_W-1:0] DIM_RESET = 3'd4;

  // Q1.14 value of one.
  localparam logic [QUOT_W:0] UNIT_ONE = 17'd16384;

  typedef struct packed {
    logic signed [COMP_W-1:0] comp_x;
    logic signed [COMP_W-1:0] comp_y;
    logic signed [COMP_W-1:0] comp_z;
    logic signed [COMP_W-1:0] comp_w;
  } vln_in_t;

  typedef struct packed {
    logic signed [UNIT_W-1:0] unit_x;
    logic signed [UNIT_W-1:0] unit_y;
    logic signed [UNIT_W-1:0] unit_z;
    logic signed [UNIT_W-1:0] unit_w;
    logic [MAG_W-1:0]         magnitude;
    logic [MSQ_W-1:0]         magnitude_squared;
    logic                     zero_length;
  } vln_out_t;

endpackage

FILE: hw/rtl/vln_sumsq.sv
// Front stages: component magnitudes, squares and the saturated sum of squares.
// Four register stages. Depends on vln_pkg.
module vln_sumsq import vln_pkg::*; #(
  parameter int unsigned CB = 16,
  parameter int unsigned SW = 33
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic                    in_valid,
  input  vln_in_t                 in_data,
  input  logic [DIM_W-1:0]        dim,
  output logic                    out_valid,
  output logic [SW-1:0]           out_sum,
  output logic [LANES-1:0][CB-1:0] out_mag,
  output logic [LANES-1:0]        out_neg
);

  localparam int unsigned FULL_W = 2 * CB + 2;

  logic [LANES-1:0][COMP_W-1:0] raw;
  logic [LANES-1:0][CB-1:0]     mag_nxt;
  logic [LANES-1:0]             neg_nxt;
  logic [LANES-1:0]             use_lane;

  logic                          va_r, vb_r, vc_r, vd_r;
  logic [LANES-1:0][CB-1:0]      mag_a_r, mag_b_r, mag_c_r, mag_d_r;
  logic [LANES-1:0]              neg_a_r, neg_b_r, neg_c_r, neg_d_r;
  logic [LANES-1:0][2*CB-1:0]    sq_b_r;
  logic [2*CB:0]                 p0_c_r, p1_c_r;
  logic [FULL_W-1:0]             sum_full;
  logic [SW-1:0]                 sum_d_r;

  assign raw = {in_data.comp_w, in_data.comp_z, in_data.comp_y, in_data.comp_x};

  // Lanes in use: x and y always, z from three, w from four; out-of-range codes clamp.
  always_comb begin
    use_lane = 4'b0011;
    if (dim > DIM_MIN) begin
      use_lane[2] = 1'b1;
    end
    if (dim >= DIM_MAX) begin
      use_lane[3] = 1'b1;
    end
  end

  // Absolute value and sign of each used component.
  for (genvar i = 0; i < LANES; i++) begin : g_abs
    logic [CB+COMP_W-1:0] ext;
    logic [CB-1:0]        v;
    assign ext = {{CB{1'b0}}, raw[i]};
    assign v = use_lane[i] ? ext[CB-1:0] : '0;
    assign neg_nxt[i] = v[CB-1];
    assign mag_nxt[i] = v[CB-1] ? (~v + 1'b1) : v;
  end

  // Pipeline registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
      vd_r <= 1'b0;
    end else if (en) begin
      va_r <= in_valid;
      vb_r <= va_r;
      vc_r <= vb_r;
      vd_r <= vc_r;
    end
  end

  assign sum_full = FULL_W'(p0_c_r) + FULL_W'(p1_c_r);

  always_ff @(posedge clk) begin
    if (en) begin
      mag_a_r <= mag_nxt;
      neg_a_r <= neg_nxt;
      for (int i = 0; i < LANES; i++) begin
        sq_b_r[i] <= (2*CB)'(mag_a_r[i]) * (2*CB)'(mag_a_r[i]);
      end
      mag_b_r <= mag_a_r;
      neg_b_r <= neg_a_r;
      p0_c_r  <= (2*CB+1)'(sq_b_r[0]) + (2*CB+1)'(sq_b_r[1]);
      p1_c_r  <= (2*CB+1)'(sq_b_r[2]) + (2*CB+1)'(sq_b_r[3]);
      mag_c_r <= mag_b_r;
      neg_c_r <= neg_b_r;
      // Sum saturates where it outgrows the sum width.
      sum_d_r <= (|sum_full[FULL_W-1:SW]) ? '1 : sum_full[SW-1:0];
      mag_d_r <= mag_c_r;
      neg_d_r <= neg_c_r;
    end
  end

  assign out_valid = vd_r;
  assign out_sum   = sum_d_r;
  assign out_mag   = mag_d_r;
  assign out_neg   = neg_d_r;

endmodule

FILE: hw/rtl/vln_isqrt.sv
// Pipelined integer square root, one root bit per register stage.
// Carries a side tag alongside each value. Depends on vln_pkg.
module vln_isqrt import vln_pkg::*; #(
  parameter int unsigned W     = 33,
  parameter int unsigned TAG_W = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  in_valid,
  input  logic [W-1:0]          in_val,
  input  logic [TAG_W-1:0]      in_tag,
  output logic                  out_valid,
  output logic [(W+1)/2-1:0]    out_root,
  output logic [TAG_W-1:0]      out_tag
);

  localparam int unsigned RW = (W + 1) / 2;

  logic              valid_r [1:RW];
  logic [RW:0]       rem_r   [1:RW];
  logic [RW-1:0]     root_r  [1:RW];
  logic [2*RW-1:0]   bits_r  [1:RW];
  logic [TAG_W-1:0]  tag_r   [1:RW];

  for (genvar k = 0; k < RW; k++) begin : g_step
    logic              s_valid;
    logic [RW:0]       s_rem;
    logic [RW-1:0]     s_root;
    logic [2*RW-1:0]   s_bits;
    logic [TAG_W-1:0]  s_tag;
    logic [RW+2:0]     cur;
    logic [RW+2:0]     trial;
    logic [RW+2:0]     diff;
    logic              ge;

    if (k == 0) begin : g_src_in
      assign s_valid = in_valid;
      assign s_rem   = '0;
      assign s_root  = '0;
      assign s_bits  = (2*RW)'(in_val);
      assign s_tag   = in_tag;
    end else begin : g_src_reg
      assign s_valid = valid_r[k];
      assign s_rem   = rem_r[k];
      assign s_root  = root_r[k];
      assign s_bits  = bits_r[k];
      assign s_tag   = tag_r[k];
    end

    // Bring down the next two bits and try the next root bit.
    assign cur   = {s_rem, s_bits[2*RW-1 -: 2]};
    assign trial = (RW+3)'({s_root, 2'b01});
    assign diff  = cur - trial;
    assign ge    = (cur >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[k+1] <= 1'b0;
      end else if (en) begin
        valid_r[k+1] <= s_valid;
      end
    end

    // The remainder never exceeds twice the root, so its low bits hold it.
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k+1]  <= ge ? diff[RW:0] : cur[RW:0];
        root_r[k+1] <= {s_root[RW-2:0], ge};
        bits_r[k+1] <= {s_bits[2*RW-3:0], 2'b00};
        tag_r[k+1]  <= s_tag;
      end
    end
  end

  assign out_valid = valid_r[RW];
  assign out_root  = root_r[RW];
  assign out_tag   = tag_r[RW];

endmodule

FILE: hw/rtl/vln_div.sv
// Four-lane pipelined restoring divider, one quotient bit per register stage.
// Returns floor(mag * 2^15 / divisor) for each lane. Depends on vln_pkg.
module vln_div import vln_pkg::*; #(
  parameter int unsigned DW    = 17,
  parameter int unsigned MW    = 16,
  parameter int unsigned TAG_W = 8
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic [DW-1:0]               in_div,
  input  logic [LANES-1:0][MW-1:0]    in_mag,
  input  logic [TAG_W-1:0]            in_tag,
  output logic                        out_valid,
  output logic [LANES-1:0][QUOT_W-1:0] out_quot,
  output logic [TAG_W-1:0]            out_tag
);

  localparam int unsigned STEPS = QUOT_W;

  logic                              valid_r [1:STEPS];
  logic [DW-1:0]                     div_r   [1:STEPS];
  logic [LANES-1:0][DW:0]            rem_r   [1:STEPS];
  logic [LANES-1:0][QUOT_W-1:0]      quot_r  [1:STEPS];
  logic [TAG_W-1:0]                  tag_r   [1:STEPS];

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    logic                          s_valid;
    logic [DW-1:0]                 s_div;
    logic [LANES-1:0][DW:0]        cur;
    logic [LANES-1:0][QUOT_W-1:0]  s_quot;
    logic [TAG_W-1:0]              s_tag;
    logic [LANES-1:0][DW:0]        rem_nxt;
    logic [LANES-1:0][QUOT_W-1:0]  quot_nxt;

    // The first step compares the magnitude itself, later ones the doubled remainder.
    if (k == 0) begin : g_src_in
      assign s_valid = in_valid;
      assign s_div   = in_div;
      assign s_quot  = '0;
      assign s_tag   = in_tag;
      for (genvar i = 0; i < LANES; i++) begin : g_ld
        assign cur[i] = (DW+1)'(in_mag[i]);
      end
    end else begin : g_src_reg
      assign s_valid = valid_r[k];
      assign s_div   = div_r[k];
      assign s_quot  = quot_r[k];
      assign s_tag   = tag_r[k];
      for (genvar i = 0; i < LANES; i++) begin : g_sh
        assign cur[i] = {rem_r[k][i][DW-1:0], 1'b0};
      end
    end

    // Trial subtraction in every lane.
    for (genvar i = 0; i < LANES; i++) begin : g_lane
      logic ge;
      assign ge          = (cur[i] >= (DW+1)'(s_div));
      assign rem_nxt[i]  = ge ? (cur[i] - (DW+1)'(s_div)) : cur[i];
      assign quot_nxt[i] = {s_quot[i][QUOT_W-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[k+1] <= 1'b0;
      end else if (en) begin
        valid_r[k+1] <= s_valid;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        div_r[k+1]  <= s_div;
        rem_r[k+1]  <= rem_nxt;
        quot_r[k+1] <= quot_nxt;
        tag_r[k+1]  <= s_tag;
      end
    end
  end

  assign out_valid = valid_r[STEPS];
  assign out_quot  = quot_r[STEPS];
  assign out_tag   = tag_r[STEPS];

endmodule

FILE: hw/rtl/vector_length_normalize_unit.sv
// Vector length normalize unit: squared length, length and unit vector of a 2-4D vector.
// Pipeline: four front stages, one square-root stage per root bit, one divider stage per
// quotient bit and one output register.
// Throughput is one request per cycle; a stall on the result side holds every stage.
// Synchronous active-low reset clears all valid bits and sets dimension to four.
// Depends on vln_pkg, vln_sumsq, vln_isqrt and vln_div.
module vector_length_normalize_unit import vln_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  vln_in_t          in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output vln_out_t         out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [DIM_W-1:0] cfg_data
);

  localparam int unsigned CB    = COMP_W;
  localparam int unsigned SW    = (2 * CB + 1 > 64) ? 64 : 2 * CB + 1;
  localparam int unsigned RW    = (SW + 1) / 2;
  localparam int unsigned TAG1_W = SW + LANES * CB + LANES;
  localparam int unsigned TAG2_W = MSQ_W + MAG_W + 1 + LANES;

  logic                          en;
  logic [DIM_W-1:0]              dim_r;

  logic                          s_valid;
  logic [SW-1:0]                 s_sum;
  logic [LANES-1:0][CB-1:0]      s_mag;
  logic [LANES-1:0]              s_neg;

  logic                          r_valid;
  logic [RW-1:0]                 r_root;
  logic [TAG1_W-1:0]             r_tag;
  logic [SW-1:0]                 r_sum;
  logic [LANES-1:0][CB-1:0]      r_mag;
  logic [LANES-1:0]              r_neg;
  logic [64:0]                   sum_ext;
  logic [32:0]                   root_ext;
  logic [TAG2_W-1:0]             div_tag_in;

  logic                          d_valid;
  logic [LANES-1:0][QUOT_W-1:0]  d_quot;
  logic [TAG2_W-1:0]             d_tag;
  logic [MSQ_W-1:0]              d_msq;
  logic [MAG_W-1:0]              d_len;
  logic                          d_zero;
  logic [LANES-1:0]              d_neg;
  logic [LANES-1:0][UNIT_W-1:0]  unit;

  logic                          out_valid_r;
  vln_out_t                      out_data_r;

  // The whole pipeline advances unless a held result blocks it.
  assign en        = out_ready || !out_valid_r;
  assign in_ready  = en;
  assign cfg_ready = 1'b1;

  // Dimension register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dim_r <= DIM_RESET;
    end else if (cfg_valid) begin
      dim_r <= cfg_data;
    end
  end

  vln_sumsq #(.CB(CB), .SW(SW)) u_sumsq (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .dim       (dim_r),
    .out_valid (s_valid),
    .out_sum   (s_sum),
    .out_mag   (s_mag),
    .out_neg   (s_neg)
  );

  vln_isqrt #(.W(SW), .TAG_W(TAG1_W)) u_isqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (s_valid),
    .in_val    (s_sum),
    .in_tag    ({s_sum, s_mag, s_neg}),
    .out_valid (r_valid),
    .out_root  (r_root),
    .out_tag   (r_tag)
  );

  assign {r_sum, r_mag, r_neg} = r_tag;

  // Clamp the squared length and the length to their field widths.
  assign sum_ext  = 65'(r_sum);
  assign root_ext = 33'(r_root);
  assign div_tag_in = {
    (|sum_ext[64:MSQ_W]) ? {MSQ_W{1'b1}} : sum_ext[MSQ_W-1:0],
    (|root_ext[32:MAG_W]) ? {MAG_W{1'b1}} : root_ext[MAG_W-1:0],
    (r_sum == '0),
    r_neg
  };

  vln_div #(.DW(RW), .MW(CB), .TAG_W(TAG2_W)) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (r_valid),
    .in_div    (r_root),
    .in_mag    (r_mag),
    .in_tag    (div_tag_in),
    .out_valid (d_valid),
    .out_quot  (d_quot),
    .out_tag   (d_tag)
  );

  assign {d_msq, d_len, d_zero, d_neg} = d_tag;

  // Round half up, clamp to one and restore the sign; a zero-length vector gives zero.
  for (genvar i = 0; i < LANES; i++) begin : g_unit
    logic [QUOT_W:0] q;
    logic [QUOT_W:0] qc;
    assign q  = (17'(d_quot[i]) + 17'd1) >> 1;
    assign qc = (q > UNIT_ONE) ? UNIT_ONE : q;
    assign unit[i] = d_zero ? '0 : (d_neg[i] ? (~qc[UNIT_W-1:0] + 1'b1) : qc[UNIT_W-1:0]);
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r.unit_x            <= unit[0];
      out_data_r.unit_y            <= unit[1];
      out_data_r.unit_z            <= unit[2];
      out_data_r.unit_w            <= unit[3];
      out_data_r.magnitude         <= d_len;
      out_data_r.magnitude_squared <= d_msq;
      out_data_r.zero_length       <= d_zero;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
